@@ hdl/tle_pkg.sv @@
// Shared types, constants and helper functions for the terminal line editor.
package tle_pkg;

    // Line store depth and the width of the fill count, which must hold the depth itself.
    localparam int LINE_DEPTH = 32;
    localparam int FILL_W     = $clog2(LINE_DEPTH + 1);

    localparam int CHAR_W  = 8;
    localparam int DEST_W  = 2;
    localparam int MODE_W  = 4;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTR_CHAR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSP_CHAR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERASE_CHAR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EOF_CHAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVER_KEY = 3'd5;

    // Result destinations.
    localparam logic [DEST_W-1:0] DEST_TERM   = 2'd0;
    localparam logic [DEST_W-1:0] DEST_READER = 2'd1;
    localparam logic [DEST_W-1:0] DEST_SIGNAL = 2'd2;
    localparam logic [DEST_W-1:0] DEST_CMD    = 2'd3;

    // Signal codes.
    localparam logic [CHAR_W-1:0] SIG_INTERRUPT = 8'd0;
    localparam logic [CHAR_W-1:0] SIG_SUSPEND   = 8'd1;

    // Special characters.
    localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_NL = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_FF = 8'd12;
    localparam logic [CHAR_W-1:0] CMD_VALUE = 8'd0;

    // Mode flag bit positions.
    localparam int MODE_CANON = 0;
    localparam int MODE_CRNL  = 1;
    localparam int MODE_ECHO  = 2;
    localparam int MODE_ISIG  = 3;

    typedef struct packed {
        logic [MODE_W-1:0] mode_flags;
        logic [CHAR_W-1:0] interrupt_char;
        logic [CHAR_W-1:0] suspend_char;
        logic [CHAR_W-1:0] erase_char;
        logic [CHAR_W-1:0] end_of_file_char;
        logic [CHAR_W-1:0] driver_key;
    } cfg_t;

    // Decision taken for one received character.
    typedef struct packed {
        logic              ff_echo;
        logic              cmd;
        logic              echo;
        logic              sig;
        logic [CHAR_W-1:0] sig_code;
        logic              erase;
        logic              store;
        logic              flush;
        logic [CHAR_W-1:0] ch;
    } plan_t;

    // Results still owed for the item in progress, in emission order.
    typedef struct packed {
        logic ff_echo;
        logic cmd;
        logic echo;
        logic sig;
        logic flush;
    } pend_t;

    // Per-cell controls for the line store.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FORM_FEED,
        ST_CMD,
        ST_ECHO,
        ST_SIGNAL,
        ST_FLUSH
    } state_t;

    // First state that still owes a result.
    function automatic state_t pick_state(input pend_t p);
        state_t s;
        if (p.ff_echo)
            s = ST_FORM_FEED;
        else if (p.cmd)
            s = ST_CMD;
        else if (p.echo)
            s = ST_ECHO;
        else if (p.sig)
            s = ST_SIGNAL;
        else if (p.flush)
            s = ST_FLUSH;
        else
            s = ST_IDLE;
        return s;
    endfunction

endpackage

@@ hdl/terminal_line_editor_unit.sv @@
// Top level of the terminal line editor: configuration, sequencer and the row of line cells.
//
// Usage:
//   Received characters enter on the s_axis channel (tdata = in_char, tuser = bypass_mode).
//   Results leave on the m_axis channel (tdata = out_value, tuser = destination), with
//   tlast set on the final result caused by one character. A character that causes no
//   result (a stored character without flush or an erase, with echo off) is taken and
//   the block is ready again in the next cycle.
//   One character is in work at a time. The first result shows in the cycle after the
//   request is taken, and the results follow at one per cycle while the receiver is
//   ready; a line flush sends the stored characters one per cycle while the receiver
//   is ready, as the line cells shift one byte toward cell zero for each one taken.
//   At most 2 + LINE_DEPTH results follow one character.
//   s_axis_tready is high only while no result is pending. When the receiver stalls,
//   the current result and its tlast stay on the port until taken.
//   Configuration writes on cfg_we/cfg_index/cfg_data take effect at the next edge and
//   are meant for idle periods only. Reset sets the registers to their defaults,
//   empties the line and returns the sequencer to idle; the cell bytes are not cleared
//   since only stored entries are ever read.
module terminal_line_editor_unit
    import tle_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CHAR_W-1:0]    s_axis_tdata,   // [7:0] in_char
    input  logic                 s_axis_tuser,   // [0] bypass_mode

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [CHAR_W-1:0]    m_axis_tdata,   // [7:0] out_value
    output logic [DEST_W-1:0]    m_axis_tuser,   // [1:0] destination
    output logic                 m_axis_tlast,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHAR_W-1:0]    cfg_data
);

    cfg_t              cfg_reg;
    plan_t             plan;
    state_t            state_reg;
    state_t            state_next;
    pend_t             pend_reg;
    pend_t             pend_next;
    pend_t             pend_rest;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] stored_fill;
    logic [FILL_W-1:0] cnt_reg;
    logic [FILL_W-1:0] cnt_next;
    logic [CHAR_W-1:0] ch_reg;
    logic [CHAR_W-1:0] sig_code_reg;
    logic              in_accept;
    logic              out_accept;
    logic              store_we;
    logic [CHAR_W-1:0] cell_data [LINE_DEPTH];

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_flags       <= 4'd15;
            cfg_reg.interrupt_char   <= 8'd3;
            cfg_reg.suspend_char     <= 8'd26;
            cfg_reg.erase_char       <= 8'd127;
            cfg_reg.end_of_file_char <= 8'd4;
            cfg_reg.driver_key       <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE_FLAGS: cfg_reg.mode_flags       <= cfg_data[MODE_W-1:0];
                REG_INTR_CHAR:  cfg_reg.interrupt_char   <= cfg_data;
                REG_SUSP_CHAR:  cfg_reg.suspend_char     <= cfg_data;
                REG_ERASE_CHAR: cfg_reg.erase_char       <= cfg_data;
                REG_EOF_CHAR:   cfg_reg.end_of_file_char <= cfg_data;
                REG_DRIVER_KEY: cfg_reg.driver_key       <= cfg_data;
                default:        ;
            endcase
        end
    end

    tle_classify u_classify (
        .in_char     (s_axis_tdata),
        .bypass_mode (s_axis_tuser),
        .cfg         (cfg_reg),
        .plan        (plan)
    );

    // Fill count update; a flush hands the new count to the sequencer and empties the line, as does a signal.
    always_comb
    begin
        store_we    = in_accept && plan.store && (fill_reg < FILL_W'(LINE_DEPTH));
        stored_fill = store_we ? fill_reg + 1'b1 : fill_reg;
        fill_next   = fill_reg;
        if (in_accept)
        begin
            if (plan.sig)
                fill_next = '0;
            else if (plan.erase)
                fill_next = (fill_reg != '0) ? fill_reg - 1'b1 : fill_reg;
            else if (plan.flush)
                fill_next = '0;
            else
                fill_next = stored_fill;
        end
    end

    // Sequencer next state: walk the pending results in order.
    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    pend_next.ff_echo = plan.ff_echo;
                    pend_next.cmd     = plan.cmd;
                    pend_next.echo    = plan.echo;
                    pend_next.sig     = plan.sig;
                    pend_next.flush   = plan.flush && (stored_fill != '0);
                    cnt_next          = stored_fill;
                    state_next        = pick_state(pend_next);
                end
            end
            ST_FORM_FEED:
            begin
                if (m_axis_tready)
                begin
                    pend_next.ff_echo = 1'b0;
                    state_next        = pick_state(pend_next);
                end
            end
            ST_CMD:
            begin
                if (m_axis_tready)
                begin
                    pend_next.cmd = 1'b0;
                    state_next    = pick_state(pend_next);
                end
            end
            ST_ECHO:
            begin
                if (m_axis_tready)
                begin
                    pend_next.echo = 1'b0;
                    state_next     = pick_state(pend_next);
                end
            end
            ST_SIGNAL:
            begin
                if (m_axis_tready)
                begin
                    pend_next.sig = 1'b0;
                    state_next    = pick_state(pend_next);
                end
            end
            ST_FLUSH:
            begin
                if (m_axis_tready)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == FILL_W'(1))
                        pend_next.flush = 1'b0;
                    state_next = pick_state(pend_next);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                pend_next  = '0;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = 1'b0;
        m_axis_tuser  = DEST_TERM;
        m_axis_tdata  = ch_reg;
        pend_rest     = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                pend_rest = '0;
            end
            ST_FORM_FEED:
            begin
                m_axis_tvalid     = 1'b1;
                m_axis_tuser      = DEST_TERM;
                m_axis_tdata      = CHAR_FF;
                pend_rest.ff_echo = 1'b0;
            end
            ST_CMD:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tuser  = DEST_CMD;
                m_axis_tdata  = CMD_VALUE;
                pend_rest.cmd = 1'b0;
            end
            ST_ECHO:
            begin
                m_axis_tvalid  = 1'b1;
                m_axis_tuser   = DEST_TERM;
                m_axis_tdata   = ch_reg;
                pend_rest.echo = 1'b0;
            end
            ST_SIGNAL:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tuser  = DEST_SIGNAL;
                m_axis_tdata  = sig_code_reg;
                pend_rest.sig = 1'b0;
            end
            ST_FLUSH:
            begin
                m_axis_tvalid   = 1'b1;
                m_axis_tuser    = DEST_READER;
                m_axis_tdata    = cell_data[0];
                pend_rest.flush = (cnt_reg != FILL_W'(1));
            end
            default:
            begin
                pend_rest = '0;
            end
        endcase
        m_axis_tlast = m_axis_tvalid && (pend_rest == '0);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
            cnt_reg   <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
        end
    end

    // Item payload held for the echo and signal results.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ch_reg       <= plan.ch;
            sig_code_reg <= plan.sig_code;
        end
    end

    // Row of line cells; cell zero feeds the reader during a flush.
    for (genvar i = 0; i < LINE_DEPTH; i++)
    begin : g_cell
        cell_ctl_t         ctl;
        logic [CHAR_W-1:0] shift_in;

        assign ctl.load  = store_we && (fill_reg == FILL_W'(i));
        assign ctl.shift = (state_reg == ST_FLUSH) && m_axis_tready;

        if (i == LINE_DEPTH - 1)
        begin : g_tail
            assign shift_in = '0;
        end
        else
        begin : g_body
            assign shift_in = cell_data[i+1];
        end

        tle_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .load_data (plan.ch),
            .shift_in  (shift_in),
            .data      (cell_data[i])
        );
    end

    // Only one item is in work: no request is taken while a result is pending.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while a result is pending");

    // The line never holds more than its depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(LINE_DEPTH))
        else $error("fill count beyond line depth");

    // A flush always has at least one stored character left to send.
    a_flush_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (cnt_reg != '0) && (cnt_reg <= FILL_W'(LINE_DEPTH)))
        else $error("flush with no characters left");

    // After the final result of an item is taken, the block is ready again.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && m_axis_tlast |=> s_axis_tready)
        else $error("block not ready after final result");

endmodule

@@ hdl/tle_cell.sv @@
// One byte cell of the line store: loads a new character or takes its neighbor's byte.
module tle_cell
    import tle_pkg::*;
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [CHAR_W-1:0] load_data,
    input  logic [CHAR_W-1:0] shift_in,
    output logic [CHAR_W-1:0] data
);

    logic [CHAR_W-1:0] data_reg;
    logic [CHAR_W-1:0] data_next;

    // A load wins; during a flush the row moves one place toward cell zero.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.load)
            data_next = load_data;
        else if (ctl.shift)
            data_next = shift_in;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ hdl/tle_classify.sv @@
// Decides what one received character causes, given the configuration.
module tle_classify
    import tle_pkg::*;
(
    input  logic [CHAR_W-1:0] in_char,
    input  logic              bypass_mode,
    input  cfg_t              cfg,
    output plan_t             plan
);

    logic              cr_conv;
    logic              is_ff;
    logic              is_cmd;
    logic              rest;
    logic              is_sig;
    logic              is_erase;
    logic              is_store;
    logic [CHAR_W-1:0] ch;

    always_comb
    begin
        // Carriage return conversion, then the form feed and driver key tests.
        cr_conv = (in_char == CHAR_CR) && cfg.mode_flags[MODE_CRNL];
        ch      = cr_conv ? CHAR_NL : in_char;
        is_ff   = !cr_conv && (in_char == CHAR_FF);
        is_cmd  = !cr_conv && !is_ff && (in_char == cfg.driver_key);
        rest    = !is_cmd && !bypass_mode;

        // Signals, erase and storage apply only outside bypass mode and never to the driver key.
        is_sig   = rest && cfg.mode_flags[MODE_ISIG]
                   && ((ch == cfg.interrupt_char) || (ch == cfg.suspend_char));
        is_erase = rest && !is_sig && (ch == cfg.erase_char) && cfg.mode_flags[MODE_CANON];
        is_store = rest && !is_sig && !is_erase;

        plan.ff_echo  = is_ff;
        plan.cmd      = is_cmd;
        plan.echo     = !is_cmd && (cfg.mode_flags[MODE_ECHO] || bypass_mode);
        plan.sig      = is_sig;
        plan.sig_code = (ch == cfg.interrupt_char) ? SIG_INTERRUPT : SIG_SUSPEND;
        plan.erase    = is_erase;
        plan.store    = is_store;
        plan.flush    = is_store && ((ch == CHAR_NL) || (ch == cfg.end_of_file_char)
                                     || !cfg.mode_flags[MODE_CANON]);
        plan.ch       = ch;
    end

endmodule
